// ===== src/spq_pkg.sv =====
// spq_pkg: word types and command codes for the sorted priority queue
// no dependencies; used by sorted_priority_queue and spq_store
`default_nettype none

package spq_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  priority_req;
      logic [15:0] tag;
   } req_word_type;

   typedef struct packed {
      logic        accepted;
      logic        top_valid;
      logic [15:0] top_tag;
      logic [7:0]  top_priority;
      logic        full_res;
      logic [5:0]  count;
   } rsp_word_type;

   // one slot of the sorted array
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] tag;
   } entry_type;

endpackage

`default_nettype wire

// ===== src/spq_store.sv =====
// spq_store: slot memory, one write and one registered read per cycle
// depends on spq_pkg (entry_type)
`default_nettype none

module spq_store
   import spq_pkg::*;
#(
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic      clock,
   input  wire logic      wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire entry_type wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output entry_type      rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue.sv =====
// sorted_priority_queue: top level, command sequencer with shared compare
// and shift step over the slot memory; depends on spq_pkg and spq_store
//
//   port group   dir   handshake              word
//   req_         in    req_valid / req_stall  req_word_type
//   rsp_         out   rsp_valid / rsp_stall  rsp_word_type
//
// remove, query, refused insert and insert into an empty queue go IDLE, TOP, FIN
// an insert goes IDLE, then CMP for each slot compared, then PLACE if every held
// entry moved up, then TOP and FIN; CMP reads, compares and writes one slot per cycle
// reset clears state, occupancy and rsp_valid only; slots are written before they are ever read
// a new word is taken while a finished result still waits on rsp_stall
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_stall,
   input  wire req_word_type req_word,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int AW = $clog2(DEPTH);
   localparam int OW = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_PLACE,
      ST_TOP,
      ST_FIN
   } state_type;

   state_type    state_ff, state_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [OW-1:0] pos_ff, pos_in;
   logic [7:0]   prio_ff, prio_in;
   logic [15:0]  tag_ff, tag_in;
   logic         ok_ff, ok_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic         wr_en;
   logic [AW-1:0] wr_addr;
   entry_type    wr_data;
   logic [AW-1:0] rd_addr;
   entry_type    rd_data;

   logic [OW-1:0] pos_dec;
   logic [OW-1:0] occ_dec;
   logic [OW+5:0] occ_wide;
   logic         occ_full;
   logic         occ_empty;
   logic         move_up;
   entry_type    new_entry;

   spq_store #(.DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pos_dec   = pos_ff - OW'(1);
   assign occ_dec   = occ_ff - OW'(1);
   assign occ_wide  = {6'b0, occ_ff};
   assign occ_full  = (occ_ff == OW'(DEPTH));
   assign occ_empty = (occ_ff == '0);
   assign new_entry = '{prio: prio_ff, tag: tag_ff};
   // shared compare: held entry of equal or higher priority moves up
   assign move_up   = (rd_data.prio >= prio_ff);

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      pos_in       = pos_ff;
      prio_in      = prio_ff;
      tag_in       = tag_ff;
      ok_in        = ok_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff[AW-1:0];
      wr_data      = new_entry;
      rd_addr      = occ_dec[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               prio_in  = req_word.priority_req;
               tag_in   = req_word.tag;
               ok_in    = 1'b0;
               state_in = ST_TOP;
               case (req_word.command)
                  CMD_INSERT: begin
                     if (!occ_full && occ_empty) begin
                        wr_en   = 1'b1;
                        wr_addr = '0;
                        wr_data = '{prio: req_word.priority_req, tag: req_word.tag};
                        occ_in  = OW'(1);
                        ok_in   = 1'b1;
                     end else if (!occ_full) begin
                        // read the top slot, compare next cycle
                        pos_in   = occ_ff;
                        state_in = ST_CMP;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!occ_empty) begin
                        occ_in = occ_dec;
                        ok_in  = 1'b1;
                     end
                  end
                  CMD_QUERY: begin
                     ok_in = !occ_empty;
                  end
                  default: begin
                     ok_in = 1'b0;
                  end
               endcase
            end
         end
         ST_CMP: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            if (move_up) begin
               wr_data = rd_data;
               pos_in  = pos_dec;
               rd_addr = pos_ff[AW-1:0] - AW'(2);
               if (pos_dec == '0) begin
                  state_in = ST_PLACE;
               end
            end else begin
               wr_data  = new_entry;
               occ_in   = occ_ff + OW'(1);
               ok_in    = 1'b1;
               state_in = ST_TOP;
            end
         end
         ST_PLACE: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = new_entry;
            occ_in   = occ_ff + OW'(1);
            ok_in    = 1'b1;
            state_in = ST_TOP;
         end
         ST_TOP: begin
            rd_addr  = occ_dec[AW-1:0];
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.accepted      = ok_ff;
               rsp_word_in.top_valid     = !occ_empty;
               rsp_word_in.top_tag       = occ_empty ? 16'h0 : rd_data.tag;
               rsp_word_in.top_priority  = occ_empty ? 8'h0 : rd_data.prio;
               rsp_word_in.full_res      = occ_full;
               rsp_word_in.count         = occ_wide[5:0];
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      prio_ff     <= prio_in;
      tag_ff      <= tag_in;
      ok_ff       <= ok_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(DEPTH))
      else $error("occupancy above depth");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (occ_ff == $past(occ_ff)) || (occ_ff == $past(occ_ff) + OW'(1))
               || (occ_ff == $past(occ_ff) - OW'(1)))
      else $error("occupancy moved by more than one");

   a_cmp_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (pos_ff != '0) && (pos_ff < OW'(DEPTH)))
      else $error("shift position out of range");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) && req_valid |=> (state_ff != ST_IDLE))
      else $error("accepted word did not start the sequencer");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_word_ff.top_valid |->
         (rsp_word_ff.top_tag == 16'h0) && (rsp_word_ff.top_priority == 8'h0)
         && !rsp_word_ff.full_res)
      else $error("empty queue reported a top entry");

endmodule

`default_nettype wire
